FILE: hdl/wsts_pkg.sv
// Package: shared types and codes for the work-stealing task scheduler.
package wsts_pkg;

    typedef enum logic [1:0] {
        SRC_OWN    = 2'd0,
        SRC_FIFO   = 2'd1,
        SRC_STOLEN = 2'd2,
        SRC_NONE   = 2'd3
    } t_source;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_READ,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_DEQUE,
        OP_PUSH_FIFO,
        OP_POP_OWN,
        OP_POP_FIFO,
        OP_STEAL
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic scan_init;  // start victim scan
        logic scan_step;  // advance victim scan
        t_op  op;         // operation to commit (issues memory access)
        logic finish;     // capture read data into result
        logic drop;       // overflow result
        logic none;       // empty result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_req;
        logic from_worker;
        logic own_empty;
        logic own_full;
        logic fifo_empty;
        logic fifo_full;
        logic victim_hit;
        logic scan_done;
    } t_status;

endpackage

FILE: hdl/wsts_ram.sv
// Generic single-port RAM with registered read.
module wsts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hdl/wsts_ctrl.sv
// Controller: sequences submit and request handling.
module wsts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wsts_pkg::t_status i_status,
    output wsts_pkg::t_cmd    o_cmd
);
    import wsts_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_status.is_req) begin
                    if (i_status.from_worker) begin
                        if (i_status.own_full) o_cmd.drop = 1'b1;
                        else o_cmd.op = OP_PUSH_DEQUE;
                    end else begin
                        if (i_status.fifo_full) o_cmd.drop = 1'b1;
                        else o_cmd.op = OP_PUSH_FIFO;
                    end
                    if (!(o_cmd.drop)) o_cmd.none = 1'b1;
                    n_state = ST_OUT;
                end else if (!i_status.own_empty) begin
                    o_cmd.op = OP_POP_OWN;
                    n_state  = ST_READ;
                end else if (!i_status.fifo_empty) begin
                    o_cmd.op = OP_POP_FIFO;
                    n_state  = ST_READ;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.victim_hit) begin
                    o_cmd.op = OP_STEAL;
                    n_state  = ST_READ;
                end else if (i_status.scan_done) begin
                    o_cmd.none = 1'b1;
                    n_state    = ST_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_READ: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

FILE: hdl/wsts_dp.sv
// Datapath: deque and fifo pointers, slot memories, victim scan, result.
module wsts_dp #(
    parameter int NUM_WORKERS = 4,
    parameter int DEQUE_DEPTH = 16,
    parameter int FIFO_DEPTH  = 16,
    parameter int TOKEN_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_in,
    input  logic [1:0]            i_worker,
    input  logic                  i_from_worker,
    input  logic [15:0]           i_task_token,
    input  wsts_pkg::t_cmd        i_cmd,
    output wsts_pkg::t_status     o_status,
    output logic                  o_granted,
    output logic [15:0]           o_granted_token,
    output logic [1:0]            o_source,
    output logic [1:0]            o_victim,
    output logic                  o_overflow
);
    import wsts_pkg::*;

    localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int DW = $clog2(DEQUE_DEPTH);
    localparam int FW = $clog2(FIFO_DEPTH);
    localparam int DCW = $clog2(DEQUE_DEPTH + 1);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);
    localparam int TB  = (TOKEN_BITS < 16) ? TOKEN_BITS : 16;
    localparam int MAW = $clog2(NUM_WORKERS * DEQUE_DEPTH);

    logic [DW-1:0]  r_front [NUM_WORKERS];
    logic [DCW-1:0] r_count [NUM_WORKERS];
    logic [FW-1:0]  r_fhead;
    logic [FCW-1:0] r_fcount;

    logic           r_is_req, r_fw;
    logic [WW-1:0]  r_w, r_v;
    logic [WW:0]    r_scan_n;
    logic [TB-1:0]  r_tok;
    logic           r_from_fifo;

    logic [TB-1:0]  w_drdata, w_frdata;
    logic           w_dwe, w_fwe;
    logic [MAW-1:0] w_daddr;
    logic [FW-1:0]  w_faddr;
    logic [DW-1:0]  w_slot;
    logic [WW-1:0]  w_row;

    function automatic logic [DW-1:0] dwrap(input logic [DW:0] x);
        return (x >= (DW+1)'(DEQUE_DEPTH)) ? DW'(x - (DW+1)'(DEQUE_DEPTH)) : DW'(x);
    endfunction

    function automatic logic [FW-1:0] fwrap(input logic [FW:0] x);
        return (x >= (FW+1)'(FIFO_DEPTH)) ? FW'(x - (FW+1)'(FIFO_DEPTH)) : FW'(x);
    endfunction

    // worker index taken modulo NUM_WORKERS (index is below 4, one subtract suffices for NUM_WORKERS of 2 or more)
    logic [7:0]    w_wext;
    logic [WW-1:0] w_win;
    assign w_wext = {6'd0, i_worker};
    assign w_win  = WW'((w_wext >= 8'(NUM_WORKERS)) ? w_wext - 8'(NUM_WORKERS) : w_wext);

    logic [WW-1:0] w_vnext;
    assign w_vnext = (r_v == WW'(NUM_WORKERS - 1)) ? '0 : r_v + 1'b1;

    assign o_status.is_req      = r_is_req;
    assign o_status.from_worker = r_fw;
    assign o_status.own_empty   = (r_count[r_w] == '0);
    assign o_status.own_full    = (r_count[r_w] == DCW'(DEQUE_DEPTH));
    assign o_status.fifo_empty  = (r_fcount == '0);
    assign o_status.fifo_full   = (r_fcount == FCW'(FIFO_DEPTH));
    assign o_status.victim_hit  = (r_count[r_v] != '0);
    assign o_status.scan_done   = (r_scan_n == (WW+1)'(NUM_WORKERS - 1));

    always_comb begin
        w_row  = r_w;
        w_slot = r_front[r_w];
        w_dwe  = 1'b0;
        w_fwe  = 1'b0;
        w_faddr = r_fhead;
        case (i_cmd.op)
            OP_PUSH_DEQUE: begin
                w_dwe  = 1'b1;
                w_slot = dwrap({1'b0, r_front[r_w]} + (DW+1)'(DEQUE_DEPTH - 1));
            end
            OP_PUSH_FIFO: begin
                w_fwe   = 1'b1;
                w_faddr = fwrap({1'b0, r_fhead} + (FW+1)'(r_fcount));
            end
            OP_STEAL: begin
                w_row  = r_v;
                w_slot = dwrap({1'b0, r_front[r_v]} + (DW+1)'(r_count[r_v] - 1'b1));
            end
            default: ;
        endcase
    end

    assign w_daddr = MAW'(w_row) * MAW'(DEQUE_DEPTH) + MAW'(w_slot);

    wsts_ram #(.WIDTH(TB), .DEPTH(NUM_WORKERS * DEQUE_DEPTH)) u_deque_ram (
        .i_clk(i_clk), .i_we(w_dwe), .i_addr(w_daddr),
        .i_wdata(r_tok), .o_rdata(w_drdata)
    );

    wsts_ram #(.WIDTH(TB), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .i_clk(i_clk), .i_we(w_fwe), .i_addr(w_faddr),
        .i_wdata(r_tok), .o_rdata(w_frdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_front[i] <= '0;
                r_count[i] <= '0;
            end
            r_fhead  <= '0;
            r_fcount <= '0;
        end else begin
            case (i_cmd.op)
                OP_PUSH_DEQUE: begin
                    r_front[r_w] <= w_slot;
                    r_count[r_w] <= r_count[r_w] + 1'b1;
                end
                OP_PUSH_FIFO: r_fcount <= r_fcount + 1'b1;
                OP_POP_OWN: begin
                    r_front[r_w] <= dwrap({1'b0, r_front[r_w]} + 1'b1);
                    r_count[r_w] <= r_count[r_w] - 1'b1;
                end
                OP_POP_FIFO: begin
                    r_fhead  <= fwrap({1'b0, r_fhead} + 1'b1);
                    r_fcount <= r_fcount - 1'b1;
                end
                OP_STEAL: r_count[r_v] <= r_count[r_v] - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_req <= i_cmd_in;
            r_fw     <= i_from_worker;
            r_w      <= w_win;
            r_tok    <= i_task_token[TB-1:0];
        end
        if (i_cmd.scan_init) begin
            r_v      <= (r_w == WW'(NUM_WORKERS - 1)) ? '0 : r_w + 1'b1;
            r_scan_n <= '0;
        end else if (i_cmd.scan_step) begin
            r_v      <= w_vnext;
            r_scan_n <= r_scan_n + 1'b1;
        end
        if (i_cmd.op == OP_POP_OWN) begin
            o_source <= SRC_OWN; r_from_fifo <= 1'b0;
        end else if (i_cmd.op == OP_POP_FIFO) begin
            o_source <= SRC_FIFO; r_from_fifo <= 1'b1;
        end else if (i_cmd.op == OP_STEAL) begin
            o_source <= SRC_STOLEN; r_from_fifo <= 1'b0;
        end
        if (i_cmd.finish) begin
            o_granted       <= 1'b1;
            o_granted_token <= 16'(r_from_fifo ? w_frdata : w_drdata);
            o_victim        <= (o_source == SRC_STOLEN) ? 2'(r_v) : 2'd0;
            o_overflow      <= 1'b0;
        end else if (i_cmd.drop || i_cmd.none) begin
            o_granted       <= 1'b0;
            o_granted_token <= '0;
            o_source        <= SRC_NONE;
            o_victim        <= '0;
            o_overflow      <= i_cmd.drop;
        end
    end
endmodule

FILE: hdl/work_stealing_task_scheduler_unit.sv
// Top level: work-stealing task scheduler with per-worker deques and a shared fifo.
//  channel | dir | tdata (low->high)                           | tuser
//  s_axis  | in  | cmd, worker, from_worker, task_token        | -
//  m_axis  | out | granted, granted_token, source, victim, ovf  | -
// Submit passes IDLE, DECIDE and OUT; own deque or fifo pop passes IDLE, DECIDE, READ and OUT.
// Steal: SEARCH probes the workers in turn from worker+1 until a hit, then READ and OUT; empty request: SEARCH, OUT.
// Deque and fifo slots share one single-port RAM each with registered read.
// Synchronous active-low reset clears the deque and fifo pointers and counts.
// Output holds until taken; no new word is accepted meanwhile.
module work_stealing_task_scheduler_unit #(
    parameter int NUM_WORKERS = 4,
    parameter int DEQUE_DEPTH = 16,
    parameter int FIFO_DEPTH  = 16,
    parameter int TOKEN_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // cmd, worker[1:0], from_worker, task_token[15:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // granted, granted_token[15:0], source, victim, overflow
);
    import wsts_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic        w_granted, w_overflow;
    logic [15:0] w_tok;
    logic [1:0]  w_source, w_victim;

    wsts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    wsts_dp #(
        .NUM_WORKERS(NUM_WORKERS), .DEQUE_DEPTH(DEQUE_DEPTH),
        .FIFO_DEPTH(FIFO_DEPTH), .TOKEN_BITS(TOKEN_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_in(s_axis_tdata[0]), .i_worker(s_axis_tdata[2:1]),
        .i_from_worker(s_axis_tdata[3]), .i_task_token(s_axis_tdata[19:4]),
        .i_cmd(w_cmd), .o_status(w_status),
        .o_granted(w_granted), .o_granted_token(w_tok), .o_source(w_source),
        .o_victim(w_victim), .o_overflow(w_overflow)
    );

    assign m_axis_tdata = {2'b00, w_overflow, w_victim, w_source, w_tok, w_granted};
endmodule
